// File: rtl/core/lswf_pkg.sv
package lswf_pkg;

  localparam int unsigned AngleCount = 360;
  localparam int unsigned QueueDepth = 2;

  localparam logic [5:0] CountMax = 6'd63;

  // Configuration register indexes.
  localparam logic [2:0] RegClampRange = 3'd0;
  localparam logic [2:0] RegBaseSpeed  = 3'd1;
  localparam logic [2:0] RegCreepSpeed = 3'd2;
  localparam logic [2:0] RegGainNormal = 3'd3;
  localparam logic [2:0] RegGainClose  = 3'd4;
  localparam logic [2:0] RegCornerDist = 3'd5;
  localparam logic [2:0] RegStopDist   = 3'd6;
  localparam logic [2:0] RegSpinRate   = 3'd7;

  // Reset values of the configuration registers.
  localparam logic [11:0] ClampRangeRst = 12'd2000;
  localparam logic [9:0]  BaseSpeedRst  = 10'd160;
  localparam logic [9:0]  CreepSpeedRst = 10'd50;
  localparam logic [7:0]  GainNormalRst = 8'd40;
  localparam logic [7:0]  GainCloseRst  = 8'd64;
  localparam logic [11:0] CornerDistRst = 12'd350;
  localparam logic [11:0] StopDistRst   = 12'd150;
  localparam logic [14:0] SpinRateRst   = 15'd1500;

  typedef struct packed {
    logic [11:0] clamp_range_mm;
    logic [9:0]  base_speed;
    logic [9:0]  creep_speed;
    logic [7:0]  gain_normal;
    logic [7:0]  gain_close;
    logic [11:0] corner_distance;
    logic [11:0] stop_distance;
    logic [14:0] spin_rate;
  } cfg_t;

  // One conditioned and classified sample.
  typedef struct packed {
    logic [11:0] range;
    logic        hit_front;
    logic        hit_left;
    logic        hit_right;
    logic        last;
  } sample_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [9:0]         linear_speed;
    logic signed [15:0] angular_rate;
    logic [11:0]        front_average;
    logic [11:0]        left_average;
    logic [11:0]        right_average;
  } result_t;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_LOAD,
    ST_DIV,
    ST_STEER,
    ST_MUL,
    ST_OUT
  } back_state_e;

endpackage

// File: rtl/core/lswf_front.sv
module lswf_front (
  input  logic [8:0]       angle_index_i,
  input  logic [15:0]      range_mm_i,
  input  logic             range_valid_i,
  input  logic             last_sample_i,
  input  logic [11:0]      clamp_range_i,
  output lswf_pkg::sample_t sample_o
);

  logic use_clamp;

  // Invalid, zero and over-range readings all stand in as the clamp range.
  assign use_clamp = !range_valid_i || (range_mm_i == 16'd0) ||
                     (range_mm_i > {4'd0, clamp_range_i});

  always_comb begin
    sample_o.range     = use_clamp ? clamp_range_i : range_mm_i[11:0];
    sample_o.hit_front = (angle_index_i inside {[9'd0 : 9'd10]}) ||
                         (angle_index_i inside {[9'd350 : 9'd359]});
    sample_o.hit_left  = angle_index_i inside {[9'd40 : 9'd80]};
    sample_o.hit_right = angle_index_i inside {[9'd280 : 9'd320]};
    sample_o.last      = last_sample_i;
  end

endmodule

// File: rtl/core/lswf_queue.sv
module lswf_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lswf_pkg::sample_t data_i,
  input  logic              pop_i,
  output lswf_pkg::sample_t data_o,
  output lswf_pkg::q_stat_t stat_o
);

  lswf_pkg::sample_t mem_q [lswf_pkg::QueueDepth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign stat_o.full  = (cnt_q == 2'(lswf_pkg::QueueDepth));
  assign stat_o.empty = (cnt_q == 2'd0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/core/lswf_back.sv
module lswf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lswf_pkg::cfg_t    cfg_i,
  input  lswf_pkg::sample_t sample_i,
  input  lswf_pkg::q_stat_t q_stat_i,
  output logic              q_pop_o,
  input  logic              res_pop_i,
  output logic              res_valid_o,
  output lswf_pkg::result_t res_o
);

  lswf_pkg::back_state_e state_q, state_d;

  logic [17:0] front_sum_q, left_sum_q, right_sum_q;
  logic [5:0]  front_cnt_q, left_cnt_q, right_cnt_q;
  logic [17:0] lat_sum_q [3];
  logic [5:0]  lat_cnt_q [3];
  logic [11:0] mean_q [3];

  logic [1:0]  sel_q;
  logic [4:0]  step_q;
  logic [17:0] quo_q;
  logic [5:0]  rem_q;
  logic [5:0]  div_q;
  logic [6:0]  shifted;
  logic        ge;
  logic [5:0]  rem_nxt;

  logic [11:0] mag_q;
  logic [7:0]  gain_q;
  logic        neg_q, near_q, spin_left_q;
  logic [19:0] prod_full;
  logic [15:0] prod_q;

  logic        res_valid_q;
  logic        res_free;
  logic        take, div_done;
  lswf_pkg::result_t res_q, res_d;

  assign res_free    = !res_valid_q || res_pop_i;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign take        = q_pop_o;
  assign div_done    = (step_q == 5'd17);

  // One restoring division step a cycle.
  assign shifted = {rem_q, quo_q[17]};
  assign ge      = shifted >= {1'b0, div_q};
  assign rem_nxt = ge ? 6'(shifted - {1'b0, div_q}) : shifted[5:0];

  assign prod_full = 20'(mag_q * gain_q) + 20'd8;

  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    case (state_q)
      lswf_pkg::ST_ACC: begin
        if (!q_stat_i.empty) begin
          q_pop_o = 1'b1;
          if (sample_i.last) begin
            state_d = lswf_pkg::ST_LOAD;
          end
        end
      end
      lswf_pkg::ST_LOAD:  state_d = lswf_pkg::ST_DIV;
      lswf_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = (sel_q == 2'd2) ? lswf_pkg::ST_STEER : lswf_pkg::ST_LOAD;
        end
      end
      lswf_pkg::ST_STEER: state_d = lswf_pkg::ST_MUL;
      lswf_pkg::ST_MUL:   state_d = lswf_pkg::ST_OUT;
      lswf_pkg::ST_OUT: begin
        if (res_free) begin
          state_d = lswf_pkg::ST_ACC;
        end
      end
      default: state_d = lswf_pkg::ST_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lswf_pkg::ST_ACC;
    end else begin
      state_q <= state_d;
    end
  end

  // Sector accumulators; a full sector ignores samples until the scan ends.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_sum_q <= '0;
      left_sum_q  <= '0;
      right_sum_q <= '0;
      front_cnt_q <= '0;
      left_cnt_q  <= '0;
      right_cnt_q <= '0;
    end else if (take) begin
      if (sample_i.last) begin
        front_sum_q <= '0;
        left_sum_q  <= '0;
        right_sum_q <= '0;
        front_cnt_q <= '0;
        left_cnt_q  <= '0;
        right_cnt_q <= '0;
      end else begin
        if (sample_i.hit_front && front_cnt_q != lswf_pkg::CountMax) begin
          front_sum_q <= front_sum_q + {6'd0, sample_i.range};
          front_cnt_q <= front_cnt_q + 6'd1;
        end
        if (sample_i.hit_left && left_cnt_q != lswf_pkg::CountMax) begin
          left_sum_q <= left_sum_q + {6'd0, sample_i.range};
          left_cnt_q <= left_cnt_q + 6'd1;
        end
        if (sample_i.hit_right && right_cnt_q != lswf_pkg::CountMax) begin
          right_sum_q <= right_sum_q + {6'd0, sample_i.range};
          right_cnt_q <= right_cnt_q + 6'd1;
        end
      end
    end
  end

  // Scan-end datapath: latch the totals, divide each sector, then steer.
  always_ff @(posedge clk_i) begin
    case (state_q)
      lswf_pkg::ST_ACC: begin
        if (take && sample_i.last) begin
          lat_sum_q[0] <= front_sum_q +
                          ((sample_i.hit_front && front_cnt_q != lswf_pkg::CountMax) ?
                           {6'd0, sample_i.range} : 18'd0);
          lat_cnt_q[0] <= front_cnt_q +
                          {5'd0, sample_i.hit_front && front_cnt_q != lswf_pkg::CountMax};
          lat_sum_q[1] <= left_sum_q +
                          ((sample_i.hit_left && left_cnt_q != lswf_pkg::CountMax) ?
                           {6'd0, sample_i.range} : 18'd0);
          lat_cnt_q[1] <= left_cnt_q +
                          {5'd0, sample_i.hit_left && left_cnt_q != lswf_pkg::CountMax};
          lat_sum_q[2] <= right_sum_q +
                          ((sample_i.hit_right && right_cnt_q != lswf_pkg::CountMax) ?
                           {6'd0, sample_i.range} : 18'd0);
          lat_cnt_q[2] <= right_cnt_q +
                          {5'd0, sample_i.hit_right && right_cnt_q != lswf_pkg::CountMax};
          sel_q <= 2'd0;
        end
      end
      lswf_pkg::ST_LOAD: begin
        quo_q  <= lat_sum_q[sel_q];
        div_q  <= lat_cnt_q[sel_q];
        rem_q  <= '0;
        step_q <= '0;
      end
      lswf_pkg::ST_DIV: begin
        quo_q  <= {quo_q[16:0], ge};
        rem_q  <= rem_nxt;
        step_q <= step_q + 5'd1;
        if (div_done) begin
          // The mean never exceeds the clamp range, so 12 bits hold it.
          mean_q[sel_q] <= (div_q == 6'd0) ? cfg_i.clamp_range_mm :
                           {quo_q[10:0], ge};
          sel_q <= sel_q + 2'd1;
        end
      end
      lswf_pkg::ST_STEER: begin
        neg_q       <= mean_q[2] > mean_q[1];
        mag_q       <= (mean_q[2] > mean_q[1]) ? (mean_q[2] - mean_q[1]) :
                                                 (mean_q[1] - mean_q[2]);
        gain_q      <= (mean_q[0] < cfg_i.corner_distance) ? cfg_i.gain_close :
                                                             cfg_i.gain_normal;
        near_q      <= mean_q[0] < cfg_i.stop_distance;
        spin_left_q <= mean_q[1] > mean_q[2];
      end
      lswf_pkg::ST_MUL: begin
        prod_q <= prod_full[19:4];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_d.front_average = mean_q[0];
    res_d.left_average  = mean_q[1];
    res_d.right_average = mean_q[2];
    if (near_q) begin
      res_d.linear_speed = cfg_i.creep_speed;
      res_d.angular_rate = spin_left_q ? $signed({1'b0, cfg_i.spin_rate}) :
                           $signed(16'(-$signed({1'b0, cfg_i.spin_rate})));
    end else begin
      res_d.linear_speed = cfg_i.base_speed;
      if (neg_q) begin
        res_d.angular_rate = (prod_q > 16'd32768) ? -16'sd32768 :
                             $signed(16'(-$signed({1'b0, prod_q})));
      end else begin
        res_d.angular_rate = (prod_q > 16'd32767) ? 16'sd32767 : $signed(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (state_q == lswf_pkg::ST_OUT && res_free) begin
      res_valid_q <= 1'b1;
    end else if (res_pop_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lswf_pkg::ST_OUT && res_free) begin
      res_q <= res_d;
    end
  end

endmodule

// File: rtl/core/lidar_sector_wall_follow_steer.sv
// Wall-following steering from one lidar scan. Samples enter one per cycle while not full
// through a queue interface (push/full); each range is conditioned against the clamp range
// and summed into the front, left and right sectors, and the sample flagged last produces one
// steering transaction on the result queue (empty/pop) with the three sector means. Ordinary
// samples are absorbed at one per cycle by the accumulator behind a two-entry queue. For the
// last sample of a scan, one shared restoring divider in the back end forms the three sector
// means in turn (one load plus 18 quotient bits each), followed by a steering step, a gain
// multiply step and the result write. During that time the input side keeps taking samples
// until the two-entry queue is full. A finished result waits in its own register, so the
// next scan accumulates while it is still waiting to be popped.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i and must only
// change while no scan-end transaction is pending.
module lidar_sector_wall_follow_steer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [8:0]         angle_index_i,
  input  logic [15:0]        range_mm_i,
  input  logic               range_valid_i,
  input  logic               last_sample_i,
  output logic               empty,
  input  logic               pop,
  output logic [9:0]         linear_speed_o,
  output logic signed [15:0] angular_rate_o,
  output logic [11:0]        front_average_o,
  output logic [11:0]        left_average_o,
  output logic [11:0]        right_average_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [14:0]        cfg_data_i
);

  lswf_pkg::cfg_t    cfg_q;
  lswf_pkg::sample_t front_sample;
  lswf_pkg::sample_t q_sample;
  lswf_pkg::q_stat_t q_stat;
  lswf_pkg::result_t result;
  logic              q_pop;
  logic              res_valid;

  // Configuration registers; each write keeps only the register's own width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clamp_range_mm  <= lswf_pkg::ClampRangeRst;
      cfg_q.base_speed      <= lswf_pkg::BaseSpeedRst;
      cfg_q.creep_speed     <= lswf_pkg::CreepSpeedRst;
      cfg_q.gain_normal     <= lswf_pkg::GainNormalRst;
      cfg_q.gain_close      <= lswf_pkg::GainCloseRst;
      cfg_q.corner_distance <= lswf_pkg::CornerDistRst;
      cfg_q.stop_distance   <= lswf_pkg::StopDistRst;
      cfg_q.spin_rate       <= lswf_pkg::SpinRateRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lswf_pkg::RegClampRange: cfg_q.clamp_range_mm  <= cfg_data_i[11:0];
        lswf_pkg::RegBaseSpeed:  cfg_q.base_speed      <= cfg_data_i[9:0];
        lswf_pkg::RegCreepSpeed: cfg_q.creep_speed     <= cfg_data_i[9:0];
        lswf_pkg::RegGainNormal: cfg_q.gain_normal     <= cfg_data_i[7:0];
        lswf_pkg::RegGainClose:  cfg_q.gain_close      <= cfg_data_i[7:0];
        lswf_pkg::RegCornerDist: cfg_q.corner_distance <= cfg_data_i[11:0];
        lswf_pkg::RegStopDist:   cfg_q.stop_distance   <= cfg_data_i[11:0];
        lswf_pkg::RegSpinRate:   cfg_q.spin_rate       <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Front end: condition the range and tag the sectors the angle falls in.
  lswf_front u_front (
    .angle_index_i (angle_index_i),
    .range_mm_i    (range_mm_i),
    .range_valid_i (range_valid_i),
    .last_sample_i (last_sample_i),
    .clamp_range_i (cfg_q.clamp_range_mm),
    .sample_o      (front_sample)
  );

  // The queue decouples sample intake from the scan-end division.
  lswf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_sample),
    .pop_i  (q_pop),
    .data_o (q_sample),
    .stat_o (q_stat)
  );

  assign full = q_stat.full;

  // Back end: accumulate, divide, steer and hold the result.
  lswf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .sample_i    (q_sample),
    .q_stat_i    (q_stat),
    .q_pop_o     (q_pop),
    .res_pop_i   (pop),
    .res_valid_o (res_valid),
    .res_o       (result)
  );

  assign empty           = !res_valid;
  assign linear_speed_o  = result.linear_speed;
  assign angular_rate_o  = result.angular_rate;
  assign front_average_o = result.front_average;
  assign left_average_o  = result.left_average;
  assign right_average_o = result.right_average;

  // A full queue can never also read as empty.
  a_queue_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.full |-> !q_stat.empty)
    else $error("queue reports full and empty at once");

  // The back end only takes a sample that is actually queued.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("back end popped an empty queue");

  // After the last sample of a scan the back end stops taking samples to divide.
  a_scan_end_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && q_sample.last) |=> !q_pop)
    else $error("sample taken during scan-end processing");

endmodule
